[rtl/core/whs_pkg.sv]
// Shared types and constants for the word hash direct-mapped store.
package whs_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_AW + 1;
    localparam int SUM_W      = 16;
    localparam int LEN_W      = 8;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] ACT_NEW     = 2'd0;
    localparam logic [1:0] ACT_SAME    = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
        logic             too_long;
    } word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[rtl/core/whs_front.sv]
// Front end: word scanner that accumulates byte sum and length and queues finished words of two or more characters.
module whs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  whs_pkg::fifo_status_t q_status,
    output logic                push,
    output whs_pkg::word_t      push_word
);
    import whs_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next, sum_upd;
    logic [LEN_W-1:0] len_reg, len_next, len_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    logic             is_char;
    logic             finish;
    logic             accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    assign is_char = (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                     (in_byte >= 8'h61 && in_byte <= 8'h7A);

    always_comb
    begin
        sum_upd = sum_reg;
        len_upd = len_reg;
        ovf_upd = ovf_reg;
        if (is_char)
        begin
            sum_upd = sum_reg + SUM_W'(in_byte);
            if (len_reg != {LEN_W{1'b1}})
            begin
                len_upd = len_reg + LEN_W'(1);
            end
            else
            begin
                ovf_upd = 1'b1;
            end
        end
        finish = !is_char || in_last;

        sum_next = sum_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        push     = 1'b0;
        if (accept)
        begin
            if (finish)
            begin
                push     = (len_upd >= LEN_W'(2));
                sum_next = '0;
                len_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_upd;
                len_next = len_upd;
                ovf_next = ovf_upd;
            end
        end
        push_word.sum      = sum_upd;
        push_word.len      = len_upd;
        push_word.too_long = ovf_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

[rtl/core/whs_fifo.sv]
// Short queue of finished words between the scanner and the table update.
module whs_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  whs_pkg::word_t        push_word,
    input  logic                  pop,
    output whs_pkg::word_t        head_word,
    output whs_pkg::fifo_status_t status
);
    import whs_pkg::*;

    word_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_word    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[rtl/core/whs_back.sv]
// Back end: serial modulo, slot table read-modify-write and result register.
module whs_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [whs_pkg::CNT_W-1:0]  slot_count,
    input  whs_pkg::fifo_status_t      q_status,
    input  whs_pkg::word_t             head_word,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_slot,
    output logic [1:0]                 out_action,
    output logic [whs_pkg::LEN_W-1:0]  out_len,
    output logic                       out_long
);
    import whs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              long_reg, long_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_slot_reg;
    logic [1:0]        out_action_reg, action;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_long_reg;
    logic [CNT_W-1:0]  trial;
    logic [CNT_W-1:0]  eff_slots;
    logic [SLOT_AW-1:0] mem_addr;
    logic              mem_we;
    logic              load_out;
    logic [LEN_W-1:0]  mem [SLOTS];
    logic [LEN_W-1:0]  rd_data_reg;

    assign eff_slots = (slot_count == '0 || slot_count > CNT_W'(SLOTS)) ?
                       CNT_W'(SLOTS) : slot_count;
    assign trial     = {rem_reg[SLOT_AW-1:0], dvd_reg[SUM_W-1]};
    assign mem_addr  = rem_reg[SLOT_AW-1:0];

    always_comb
    begin
        if (!valid_reg[mem_addr])
        begin
            action = ACT_NEW;
        end
        else if (rd_data_reg == len_reg)
        begin
            action = ACT_SAME;
        end
        else
        begin
            action = ACT_REPLACE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        len_next       = len_reg;
        long_next      = long_reg;
        valid_next     = valid_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    dvd_next   = head_word.sum;
                    len_next   = head_word.len;
                    long_next  = head_word.too_long;
                    rem_next   = '0;
                    div_next   = eff_slots;
                    cnt_next   = {STEP_W{1'b1}};
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = (trial >= div_reg) ? trial - div_reg : trial;
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mem_we               = 1'b1;
                    load_out             = 1'b1;
                    valid_next[mem_addr] = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        len_reg  <= len_next;
        long_reg <= long_next;
        if (load_out)
        begin
            out_slot_reg   <= 8'(mem_addr);
            out_action_reg <= action;
            out_len_reg    <= len_reg;
            out_long_reg   <= long_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= len_reg;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign out_valid  = out_valid_reg;
    assign out_slot   = out_slot_reg;
    assign out_action = out_action_reg;
    assign out_len    = out_len_reg;
    assign out_long   = out_long_reg;

endmodule

[rtl/core/word_hash_direct_mapped_store_top.sv]
// Top level of the word hash direct-mapped store.
// Word bytes are taken one per cycle while the word queue has room.
// The back end forms each result by a 16-step bit-serial modulo, then a table
// read and update.
// The back end takes a new word only after the last one is done; four queued words absorb bursts.
// Reset clears all slot valid bits at once and sets slot_count to 256.
module word_hash_direct_mapped_store_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] slot_index, [15:8] word_length
    output logic [2:0]  m_tuser,   // [1:0] action, [2] too_long
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // slot_count
);
    import whs_pkg::*;

    logic [CNT_W-1:0] slot_count_reg;
    fifo_status_t     q_status;
    word_t            push_word;
    word_t            head_word;
    logic             push;
    logic             pop;
    logic [7:0]       out_slot;
    logic [1:0]       out_action;
    logic [LEN_W-1:0] out_len;
    logic             out_long;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= CNT_W'(SLOTS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            slot_count_reg <= cfg_data;
        end
    end

    whs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_word (push_word)
    );

    whs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .status    (q_status)
    );

    whs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_count (slot_count_reg),
        .q_status   (q_status),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_slot   (out_slot),
        .out_action (out_action),
        .out_len    (out_len),
        .out_long   (out_long)
    );

    assign m_tdata = {out_len, out_slot};
    assign m_tuser = {out_long, out_action};

endmodule

[rtl/core/whs_checker.sv]
// Port-level checker for the word hash direct-mapped store, with its bind.
module whs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[1:0] != 2'd3)
        else $error("undefined action code");

    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:8] >= 8'd2)
        else $error("result for a word shorter than two characters");

    a_long_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata[15:8] == 8'd255)
        else $error("too_long set without saturated length");

endmodule

bind word_hash_direct_mapped_store_top whs_checker u_whs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
